/* rtl/ppp_pkg.sv */
// ----------------------------------------------------------------------------
// ppp_pkg
// Shared widths, register map and latency constants of the point projector.
// ----------------------------------------------------------------------------
package ppp_pkg;

  localparam int unsigned CoordW   = 32;   // Q16.16 point and eye coordinates
  localparam int unsigned RayW     = 33;   // point minus eye
  localparam int unsigned CompW    = 21;   // one Q1.19 basis component
  localparam int unsigned BasisW   = 63;   // three packed components
  localparam int unsigned ProdW    = RayW + CompW;
  localparam int unsigned DotW     = 56;   // sum of three products, sign included
  localparam int unsigned ScrW     = 17;   // unsigned Q1.16 screen coordinate
  localparam int unsigned AddrW    = 6;
  localparam int unsigned DataW    = 64;

  localparam int unsigned DivSteps = 17;   // one quotient bit per stage
  localparam int unsigned XformLat = 3;
  localparam int unsigned AxisLat  = 3 + DivSteps;
  localparam int unsigned TotalLat = XformLat + AxisLat;

  localparam logic [ScrW-1:0] ScrOne  = ScrW'(65536);
  localparam logic [ScrW-1:0] ScrHalf = ScrW'(32768);

  typedef enum logic [2:0] {
    REG_EYE_X   = 3'd0,
    REG_EYE_Y   = 3'd1,
    REG_EYE_Z   = 3'd2,
    REG_RIGHT   = 3'd3,
    REG_UP      = 3'd4,
    REG_FORWARD = 3'd5,
    REG_NEAR    = 3'd6,
    REG_HALF    = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_VISIBLE = 2'd0,
    ST_OUTSIDE = 2'd1,
    ST_BEHIND  = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [CoordW-1:0] eye_x;
    logic signed [CoordW-1:0] eye_y;
    logic signed [CoordW-1:0] eye_z;
    logic [BasisW-1:0]        right;
    logic [BasisW-1:0]        up;
    logic [BasisW-1:0]        forward;
    logic [31:0]              near_dist;
    logic [63:0]              half_extents;
  } cfg_t;

endpackage

/* rtl/ppp_cfg.sv */
// ----------------------------------------------------------------------------
// ppp_cfg
// Configuration register file behind an APB-style port.
// ----------------------------------------------------------------------------
module ppp_cfg
  import ppp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;

  assign idx    = reg_idx_e'(paddr[AddrW-1:3]);
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.eye_x        <= '0;
      cfg_q.eye_y        <= '0;
      cfg_q.eye_z        <= '0;
      cfg_q.right        <= '0;
      cfg_q.up           <= '0;
      cfg_q.forward      <= '0;
      cfg_q.near_dist    <= 32'd65536;
      cfg_q.half_extents <= 64'd281479271743489;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_EYE_X:   cfg_q.eye_x        <= pwdata[CoordW-1:0];
        REG_EYE_Y:   cfg_q.eye_y        <= pwdata[CoordW-1:0];
        REG_EYE_Z:   cfg_q.eye_z        <= pwdata[CoordW-1:0];
        REG_RIGHT:   cfg_q.right        <= pwdata[BasisW-1:0];
        REG_UP:      cfg_q.up           <= pwdata[BasisW-1:0];
        REG_FORWARD: cfg_q.forward      <= pwdata[BasisW-1:0];
        REG_NEAR:    cfg_q.near_dist    <= pwdata[31:0];
        REG_HALF:    cfg_q.half_extents <= pwdata;
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_EYE_X:   prdata = {32'd0, cfg_q.eye_x};
      REG_EYE_Y:   prdata = {32'd0, cfg_q.eye_y};
      REG_EYE_Z:   prdata = {32'd0, cfg_q.eye_z};
      REG_RIGHT:   prdata = {1'b0, cfg_q.right};
      REG_UP:      prdata = {1'b0, cfg_q.up};
      REG_FORWARD: prdata = {1'b0, cfg_q.forward};
      REG_NEAR:    prdata = {32'd0, cfg_q.near_dist};
      REG_HALF:    prdata = cfg_q.half_extents;
      default:     prdata = '0;
    endcase
  end

endmodule

/* rtl/ppp_xform.sv */
// ----------------------------------------------------------------------------
// ppp_xform
// Eye subtraction and projection onto the camera basis, three stages.
// ----------------------------------------------------------------------------
module ppp_xform
  import ppp_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [CoordW-1:0] point_x_i,
  input  logic signed [CoordW-1:0] point_y_i,
  input  logic signed [CoordW-1:0] point_z_i,
  input  cfg_t                     cfg_i,
  output logic signed [DotW-1:0]   px_o,
  output logic signed [DotW-1:0]   py_o,
  output logic signed [DotW-1:0]   pz_o
);

  logic signed [RayW-1:0]  ray_q  [3];
  logic signed [ProdW-1:0] prod_q [3][3];
  logic signed [DotW-1:0]  px_q, py_q, pz_q;
  logic [BasisW-1:0]       basis  [3];
  logic signed [DotW-1:0]  sum    [3];

  assign basis[0] = cfg_i.right;
  assign basis[1] = cfg_i.up;
  assign basis[2] = cfg_i.forward;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = DotW'(prod_q[r][0]) + DotW'(prod_q[r][1]) + DotW'(prod_q[r][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ray_q[0] <= RayW'(point_x_i) - RayW'(cfg_i.eye_x);
      ray_q[1] <= RayW'(point_y_i) - RayW'(cfg_i.eye_y);
      ray_q[2] <= RayW'(point_z_i) - RayW'(cfg_i.eye_z);
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[r][c] <= ray_q[c] * $signed(basis[r][CompW*c +: CompW]);
        end
      end
      px_q <= sum[0];
      py_q <= -sum[1];
      pz_q <= sum[2];
    end
  end

  assign px_o = px_q;
  assign py_o = py_q;
  assign pz_o = pz_q;

endmodule

/* rtl/ppp_axis.sv */
// ----------------------------------------------------------------------------
// ppp_axis
// One screen axis: near-plane scaling, frame test and a pipelined divider.
// ----------------------------------------------------------------------------
module ppp_axis
  import ppp_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [DotW-1:0] v_i,
  input  logic signed [DotW-1:0] z_i,
  input  logic [31:0]            half_i,
  input  logic [31:0]            near_i,
  output logic [ScrW-1:0]        coord_o,
  output logic                   inside_o
);

  localparam int unsigned VnW  = 88;
  localparam int unsigned RzW  = 87;
  localparam int unsigned NumW = 89;
  localparam int unsigned RemW = NumW + 15;

  // partial products
  logic [59:0]     pvl_q, pvh_q, pzl_q;
  logic [58:0]     pzh_q;
  logic            neg4_q, hz4_q;
  logic [DotW-1:0] mag;
  // summed products
  logic [VnW-1:0]  vn_q;
  logic [RzW-1:0]  rz5_q;
  logic            neg5_q, hz5_q;
  logic            outside;
  logic [NumW-1:0] num;
  // divider line, index 0 is the frame-test stage
  logic [RemW-1:0] rem_q   [DivSteps+1];
  logic [RzW-1:0]  rz_q    [DivSteps+1];
  logic [ScrW-1:0] quo_q   [DivSteps+1];
  logic [ScrW-1:0] fix_q   [DivSteps+1];
  logic            usefix_q[DivSteps+1];
  logic            in_q    [DivSteps+1];

  assign mag     = v_i[DotW-1] ? DotW'(-v_i) : DotW'(v_i);
  assign outside = vn_q > VnW'(rz5_q);
  assign num     = neg5_q ? NumW'(rz5_q) + NumW'(vn_q) : NumW'(rz5_q) - NumW'(vn_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pvl_q  <= mag[27:0] * near_i;
      pvh_q  <= mag[55:28] * near_i;
      pzl_q  <= z_i[27:0] * half_i;
      pzh_q  <= z_i[54:28] * half_i;
      neg4_q <= v_i[DotW-1];
      hz4_q  <= (half_i == '0);

      vn_q   <= VnW'(pvl_q) + (VnW'(pvh_q) << 28);
      rz5_q  <= RzW'(pzl_q) + (RzW'(pzh_q) << 28);
      neg5_q <= neg4_q;
      hz5_q  <= hz4_q;

      rem_q[0]    <= {num, 15'd0};
      rz_q[0]     <= rz5_q;
      quo_q[0]    <= '0;
      fix_q[0]    <= outside ? (neg5_q ? ScrOne : '0) : ScrHalf;
      usefix_q[0] <= outside || hz5_q;
      in_q[0]     <= !outside;

      // restoring division, quotient bit DivSteps-1-k at step k
      for (int k = 0; k < DivSteps; k++) begin
        if (rem_q[k] >= (RemW'(rz_q[k]) << (DivSteps - 1 - k))) begin
          rem_q[k+1] <= rem_q[k] - (RemW'(rz_q[k]) << (DivSteps - 1 - k));
          quo_q[k+1] <= quo_q[k] | (ScrW'(1) << (DivSteps - 1 - k));
        end else begin
          rem_q[k+1] <= rem_q[k];
          quo_q[k+1] <= quo_q[k];
        end
        rz_q[k+1]     <= rz_q[k];
        fix_q[k+1]    <= fix_q[k];
        usefix_q[k+1] <= usefix_q[k];
        in_q[k+1]     <= in_q[k];
      end
    end
  end

  assign coord_o  = usefix_q[DivSteps] ? fix_q[DivSteps] : quo_q[DivSteps];
  assign inside_o = in_q[DivSteps];

endmodule

/* rtl/perspective_point_projector.sv */
// ----------------------------------------------------------------------------
// perspective_point_projector
// Projects Q16.16 points through a look-at camera to normalized screen space.
// ----------------------------------------------------------------------------
// A new point is taken every cycle unless the output stalls. Three stages
// form the camera-space ray and its dot products; each screen axis then
// spends three stages on the near-plane products and frame test and 17 on
// a restoring divider that yields one quotient bit per stage. A stall on
// the output holds the whole pipeline. Registers are to be written over the
// APB port only while no point is in flight; the block does not enforce it.
module perspective_point_projector
  import ppp_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [AddrW-1:0]         paddr,
  input  logic [DataW-1:0]         pwdata,
  output logic [DataW-1:0]         prdata,
  output logic                     pready,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [CoordW-1:0] point_x_i,
  input  logic signed [CoordW-1:0] point_y_i,
  input  logic signed [CoordW-1:0] point_z_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [1:0]               status_o,
  output logic [ScrW-1:0]          screen_x_o,
  output logic [ScrW-1:0]          screen_y_o
);

  cfg_t                   cfg;
  logic                   en;
  logic [TotalLat-1:0]    vld_q;
  logic [AxisLat-1:0]     behind_q;
  logic signed [DotW-1:0] px, py, pz;
  logic [ScrW-1:0]        cx, cy;
  logic                   inx, iny;

  ppp_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .cfg_o(cfg)
  );

  // advance everything unless the result waits on a stalled consumer
  assign en         = !(vld_q[TotalLat-1] && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[TotalLat-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      behind_q <= {behind_q[AxisLat-2:0], (pz <= 0)};
    end
  end

  ppp_xform u_xform (
    .clk_i, .en_i(en), .point_x_i, .point_y_i, .point_z_i, .cfg_i(cfg),
    .px_o(px), .py_o(py), .pz_o(pz)
  );

  ppp_axis u_axis_x (
    .clk_i, .en_i(en), .v_i(px), .z_i(pz), .half_i(cfg.half_extents[31:0]),
    .near_i(cfg.near_dist), .coord_o(cx), .inside_o(inx)
  );

  ppp_axis u_axis_y (
    .clk_i, .en_i(en), .v_i(py), .z_i(pz), .half_i(cfg.half_extents[63:32]),
    .near_i(cfg.near_dist), .coord_o(cy), .inside_o(iny)
  );

  always_comb begin
    if (behind_q[AxisLat-1]) begin
      status_o   = ST_BEHIND;
      screen_x_o = ScrOne;
      screen_y_o = ScrOne;
    end else begin
      status_o   = (inx && iny) ? ST_VISIBLE : ST_OUTSIDE;
      screen_x_o = cx;
      screen_y_o = cy;
    end
  end

  assign out_valid_o = vld_q[TotalLat-1];

endmodule

/* sim/tb_perspective_point_projector.sv */
// ----------------------------------------------------------------------------
// tb_perspective_point_projector
// Self-checking bench for the look-at perspective point projector.
// ----------------------------------------------------------------------------
// A directed table runs first: points under the reset camera, then extremes
// and frame edges under an identity camera. Several camera setups follow,
// each with a random stream of points; most lie near the eye, the rest are
// raw noise. Both sides idle and stall at random. Rows giving results are
// checked as given; others against the bench's bit-exact projection model.
module tb_perspective_point_projector;
  import ppp_pkg::*;

  localparam int ClkHalf   = 10;
  localparam int Limit     = 400000;
  localparam int PerPhase  = 180;
  localparam int NumPhases = 7;
  localparam int LongHold  = 120;

  localparam logic [CompW-1:0]  CompOne    = 21'h080000;
  localparam logic [CompW-1:0]  CompNegOne = 21'h180000;
  localparam logic [CompW-1:0]  CompZero   = 21'h000000;
  localparam logic [CoordW-1:0] QOne       = 32'h0001_0000;
  localparam logic [CoordW-1:0] QMax       = 32'h7FFF_FFFF;
  localparam logic [CoordW-1:0] QMin       = 32'h8000_0000;

  typedef struct {
    status_e          st;
    logic [ScrW-1:0]  sx;
    logic [ScrW-1:0]  sy;
  } proj_t;

  typedef struct {
    bit               cam_setup;
    logic [31:0]      x, y, z;
    bit               typed;
    status_e          st;
    logic [ScrW-1:0]  sx, sy;
  } dir_row_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     psel, penable, pwrite;
  logic [AddrW-1:0]         paddr;
  logic [DataW-1:0]         pwdata;
  logic [DataW-1:0]         prdata;
  logic                     pready;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic signed [CoordW-1:0] point_x_i, point_y_i, point_z_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic [1:0]               status_o;
  logic [ScrW-1:0]          screen_x_o, screen_y_o;

  cfg_t  cam;
  proj_t pending[$];
  int    errors;
  int    cycles;
  int    results_seen;
  bit    quiet;

  perspective_point_projector dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o, .point_x_i, .point_y_i, .point_z_i,
    .out_valid_o, .out_stall_i, .status_o, .screen_x_o, .screen_y_o
  );

  initial begin
    clk_i = 1'b0;
    forever #ClkHalf clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > Limit) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [BasisW-1:0] pack_basis(logic [CompW-1:0] cx, logic [CompW-1:0] cy,
                                                   logic [CompW-1:0] cz);
    return {cz, cy, cx};
  endfunction

  function automatic longint dot_basis(longint rx, longint ry, longint rz,
                                       logic [BasisW-1:0] b);
    longint cx, cy, cz;
    cx = longint'($signed(b[20:0]));
    cy = longint'($signed(b[41:21]));
    cz = longint'($signed(b[62:42]));
    return rx * cx + ry * cy + rz * cz;
  endfunction

  // Map one camera-space offset to a screen coordinate; z is positive.
  function automatic logic [ScrW-1:0] screen_coord(longint v, logic [31:0] half,
                                                   logic [31:0] near, longint z,
                                                   output bit in_frame);
    logic [127:0] mag, vn, rz, num;
    mag = (v < 0) ? 128'(-v) : 128'(v);
    vn  = mag * {96'd0, near};
    rz  = {96'd0, half} * 128'(z);
    if (vn > rz) begin
      in_frame = 1'b0;
      return (v >= 0) ? ScrW'(0) : ScrOne;
    end
    in_frame = 1'b1;
    if (half == 0) return ScrHalf;
    num = (v >= 0) ? rz - vn : rz + vn;
    num = (num << 15) / rz;
    return num[ScrW-1:0];
  endfunction

  function automatic proj_t project_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    longint rx, ry, rz, px, py, pz;
    bit     in_x, in_y;
    proj_t  r;
    rx = longint'($signed(x)) - longint'(cam.eye_x);
    ry = longint'($signed(y)) - longint'(cam.eye_y);
    rz = longint'($signed(z)) - longint'(cam.eye_z);
    px = dot_basis(rx, ry, rz, cam.right);
    py = -dot_basis(rx, ry, rz, cam.up);
    pz = dot_basis(rx, ry, rz, cam.forward);
    if (pz <= 0) begin
      r.st = ST_BEHIND;
      r.sx = ScrOne;
      r.sy = ScrOne;
      return r;
    end
    r.sx = screen_coord(px, cam.half_extents[31:0], cam.near_dist, pz, in_x);
    r.sy = screen_coord(py, cam.half_extents[63:32], cam.near_dist, pz, in_y);
    r.st = (in_x && in_y) ? ST_VISIBLE : ST_OUTSIDE;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [63:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(int'(idx) * 8);
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic load_camera(input cfg_t c);
    write_reg(REG_EYE_X, 64'(c.eye_x));
    write_reg(REG_EYE_Y, 64'(c.eye_y));
    write_reg(REG_EYE_Z, 64'(c.eye_z));
    write_reg(REG_RIGHT, 64'(c.right));
    write_reg(REG_UP, 64'(c.up));
    write_reg(REG_FORWARD, 64'(c.forward));
    write_reg(REG_NEAR, 64'(c.near_dist));
    write_reg(REG_HALF, c.half_extents);
    cam = c;
  endtask

  // Lower valid and wait until every projected point has come back.
  task automatic drain_points();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    repeat (TotalLat + 4) @(posedge clk_i);
  endtask

  task automatic send_point(input logic [31:0] x, y, z, input bit typed, input proj_t res);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    point_x_i  <= x;
    point_y_i  <= y;
    point_z_i  <= z;
    do @(posedge clk_i); while (in_stall_o);
    pending.push_back(typed ? res : project_point(x, y, z));
  endtask

  function automatic logic [CompW-1:0] rand_comp();
    return CompW'($urandom);
  endfunction

  function automatic logic [31:0] rand_offset();
    int sh;
    if ($urandom_range(0, 7) == 0) return 32'd0;
    sh = $urandom_range(4, 26);
    return 32'($signed({1'b0, 31'($urandom)} >> (31 - sh)) * ($urandom_range(0, 1) ? 1 : -1));
  endfunction

  function automatic cfg_t identity_camera();
    cfg_t c;
    c.eye_x        = '0;
    c.eye_y        = '0;
    c.eye_z        = '0;
    c.right        = pack_basis(CompOne, CompZero, CompZero);
    c.up           = pack_basis(CompZero, CompOne, CompZero);
    c.forward      = pack_basis(CompZero, CompZero, CompOne);
    c.near_dist    = QOne;
    c.half_extents = {QOne, QOne};
    return c;
  endfunction

  function automatic cfg_t phase_camera(int phase);
    cfg_t c;
    c = identity_camera();
    case (phase)
      0: begin
        c.eye_x = 32'($urandom_range(0, 32'hFFFFF)) - 32'h80000;
        c.half_extents = {32'h0000_8000, 32'h0002_0000};
      end
      1: begin
        c.eye_x        = $urandom;
        c.eye_y        = $urandom;
        c.eye_z        = $urandom;
        c.right        = pack_basis(rand_comp(), rand_comp(), rand_comp());
        c.up           = pack_basis(rand_comp(), rand_comp(), rand_comp());
        c.forward      = pack_basis(rand_comp(), rand_comp(), rand_comp());
        c.near_dist    = $urandom;
        c.half_extents = {$urandom, $urandom};
      end
      2: begin
        c.near_dist    = 32'd0;
        c.half_extents = {32'($urandom_range(1, 32'h30000)), 32'($urandom_range(1, 32'h30000))};
      end
      3: begin
        c.half_extents = 64'd0;
        c.near_dist    = 32'($urandom_range(1, 32'h40000));
      end
      4: begin
        c.eye_x        = QMax;
        c.eye_y        = QMax;
        c.eye_z        = QMax;
        c.near_dist    = 32'hFFFF_FFFF;
        c.half_extents = 64'hFFFF_FFFF_FFFF_FFFF;
      end
      5: begin
        c.eye_x     = QMin;
        c.eye_y     = QMin;
        c.eye_z     = QMin;
        c.right     = pack_basis(CompNegOne, CompZero, CompZero);
        c.up        = pack_basis(CompZero, CompNegOne, CompZero);
        c.forward   = pack_basis(CompZero, CompZero, CompNegOne);
        c.near_dist = 32'd1;
        c.half_extents = {32'd1, 32'($urandom_range(1, 32'h100))};
      end
      default: begin
        c.eye_x        = 32'($urandom_range(0, 32'h3FFFFF)) - 32'h200000;
        c.eye_y        = 32'($urandom_range(0, 32'h3FFFFF)) - 32'h200000;
        c.right        = pack_basis(CompOne, rand_comp() >> 6, rand_comp() >> 6);
        c.up           = pack_basis(rand_comp() >> 6, CompOne, rand_comp() >> 6);
        c.near_dist    = $urandom_range(1, 32'h80000);
        c.half_extents = {32'($urandom_range(0, 32'h80000)), 32'($urandom_range(0, 32'h80000))};
      end
    endcase
    return c;
  endfunction

  // Receiver: random stalls per item and one long hold to back up the pipe.
  initial begin
    int    n;
    proj_t want;
    out_stall_i  = 1'b0;
    results_seen = 0;
    forever begin
      n = quiet ? 0 : $urandom_range(0, 3);
      if (results_seen == 200) n = LongHold;
      repeat (n) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      results_seen++;
      if (pending.size() == 0) begin
        report_mismatch("result with no point outstanding");
      end else begin
        want = pending.pop_front();
        if (status_o !== want.st)
          report_mismatch($sformatf("status %0d, want %0d", status_o, want.st));
        if (screen_x_o !== want.sx)
          report_mismatch($sformatf("screen_x %0d, want %0d", screen_x_o, want.sx));
        if (screen_y_o !== want.sy)
          report_mismatch($sformatf("screen_y %0d, want %0d", screen_y_o, want.sy));
      end
    end
  end

  initial begin
    dir_row_t    rows[16];
    proj_t       res;
    cfg_t        c;
    logic [31:0] x, y, z;

    rst_ni     = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    in_valid_i = 1'b0;
    point_x_i  = '0;
    point_y_i  = '0;
    point_z_i  = '0;
    errors     = 0;
    cycles     = 0;
    quiet      = 1'b1;
    cam.eye_x        = '0;
    cam.eye_y        = '0;
    cam.eye_z        = '0;
    cam.right        = '0;
    cam.up           = '0;
    cam.forward      = '0;
    cam.near_dist    = QOne;
    cam.half_extents = 64'h0001_0001_0001_0001;

    rows = '{
      // reset camera: zero basis puts every point on the eye plane
      '{0, 32'd0, 32'd0, 32'd0, 1, ST_BEHIND, ScrOne, ScrOne},
      '{0, QMax, QMax, QMax, 1, ST_BEHIND, ScrOne, ScrOne},
      '{0, QMin, QMin, QMin, 1, ST_BEHIND, ScrOne, ScrOne},
      // identity camera from here on
      '{1, 32'd0, 32'd0, QOne, 1, ST_VISIBLE, ScrHalf, ScrHalf},
      '{0, 32'd0, 32'd0, 32'hFFFF_0000, 1, ST_BEHIND, ScrOne, ScrOne},
      '{0, QOne, QOne, 32'd0, 1, ST_BEHIND, ScrOne, ScrOne},
      '{0, QMax, 32'd0, QOne, 1, ST_OUTSIDE, 17'd0, ScrHalf},
      '{0, QMin, 32'd0, QOne, 1, ST_OUTSIDE, ScrOne, ScrHalf},
      '{0, 32'd0, QMax, QOne, 1, ST_OUTSIDE, ScrHalf, ScrOne},
      '{0, 32'd0, QMin, QOne, 1, ST_OUTSIDE, ScrHalf, 17'd0},
      '{0, QOne, 32'd0, QOne, 1, ST_VISIBLE, 17'd0, ScrHalf},
      '{0, 32'hFFFF_0000, 32'd0, QOne, 1, ST_VISIBLE, ScrOne, ScrHalf},
      '{0, QMax, QMax, QMax, 1, ST_VISIBLE, 17'd0, ScrOne},
      '{0, QMin, QMin, QMin, 1, ST_BEHIND, ScrOne, ScrOne},
      '{0, 32'h0001_2345, 32'hFFFF_F889, 32'h0003_8000, 0, ST_VISIBLE, 17'd0, 17'd0},
      '{0, 32'h5555_AAAA, 32'hAAAA_5555, 32'h7FFF_0001, 0, ST_VISIBLE, 17'd0, 17'd0}
    };

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) begin
      if (rows[i].cam_setup) begin
        drain_points();
        load_camera(identity_camera());
      end
      res.st = rows[i].st;
      res.sx = rows[i].sx;
      res.sy = rows[i].sy;
      send_point(rows[i].x, rows[i].y, rows[i].z, rows[i].typed, res);
    end

    for (int phase = 0; phase < NumPhases; phase++) begin
      drain_points();
      c = phase_camera(phase);
      load_camera(c);
      quiet = (phase == 4);
      for (int k = 0; k < PerPhase; k++) begin
        if ($urandom_range(0, 9) < 3) begin
          x = $urandom;
          y = $urandom;
          z = $urandom;
        end else begin
          // land near the eye, in front of it or behind it
          x = cam.eye_x + rand_offset();
          y = cam.eye_y + rand_offset();
          z = cam.eye_z + rand_offset();
        end
        send_point(x, y, z, 1'b0, res);
      end
    end

    drain_points();
    quiet = 1'b1;
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/ppp_pkg.sv
rtl/ppp_cfg.sv
rtl/ppp_xform.sv
rtl/ppp_axis.sv
rtl/perspective_point_projector.sv
sim/tb_perspective_point_projector.sv
